>>> hdl/rate_limited_sample_history_ring_unit_assert.svh
// assertion macros for the sample history ring unit
`ifndef RATE_LIMITED_SAMPLE_HISTORY_RING_UNIT_ASSERT_SVH
`define RATE_LIMITED_SAMPLE_HISTORY_RING_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RLSH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlsh assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define RLSH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlsh assertion failed");

`endif

>>> hdl/rlsh_pkg.sv
// shared types and constants for the sample history ring unit
package rlsh_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_REC     = 3'd0;
    localparam logic [2:0] ST_REC_CLR = 3'd1;
    localparam logic [2:0] ST_SOON    = 3'd2;
    localparam logic [2:0] ST_POINT   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;
    localparam logic [2:0] ST_CLR     = 3'd5;

    localparam logic [0:0] REG_MIN_INTERVAL = 1'd0;
    localparam logic [0:0] REG_WINDOW       = 1'd1;

    localparam logic [6:0]  PCT_MAX          = 7'd100;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd300;
    localparam logic [31:0] WINDOW_RST       = 32'd86400;

    typedef struct packed {
        logic [31:0] t;
        logic [15:0] mv;
        logic [6:0]  pct;
    } entry_t;

endpackage

>>> hdl/rlsh_mem.sv
// sample store: one write port, one registered read port
module rlsh_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  rlsh_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output rlsh_pkg::entry_t rd_data
);
    import rlsh_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/rate_limited_sample_history_ring_unit.sv
// top level of the rate limited sample history ring
// record and clear: one result beat the cycle after accept; op 3 is dropped
// read: n = min(fill, point_limit); the scan reads one entry per cycle from the single read port
// of the sample memory while no result beat waits; a point passes the read and result registers
// one command at a time; a result beat that waits holds off the next command
// reset clears pointers, fill count, last time and config to 300 s / 86400 s; memory is not cleared
`include "rate_limited_sample_history_ring_unit_assert.svh"
module rate_limited_sample_history_ring_unit #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  op,
    input  logic [31:0] now_s,
    input  logic [15:0] sample_mv_in,
    input  logic [7:0]  sample_pct_in,
    input  logic [6:0]  point_limit,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [31:0] point_time_s,
    output logic [15:0] point_mv,
    output logic [6:0]  point_pct,
    output logic        last
);
    import rlsh_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 7) ? CW : 7;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [31:0]   last_time_reg, last_time_next;
    logic          has_last_reg, has_last_next;
    logic [15:0]   min_interval_reg;
    logic [31:0]   window_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [MW-1:0] remain_reg, remain_next;
    logic          pend_reg, pend_next;
    logic          pend_last_reg, pend_last_next;
    logic [31:0]   cutoff_reg, cutoff_next;

    logic          res_valid_reg, res_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   time_reg, time_next;
    logic [15:0]   mv_reg, mv_next;
    logic [6:0]    pct_reg, pct_next;
    logic          last_reg, last_next;
    logic          res_load;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    entry_t        rd_data;

    logic          out_free;
    logic          accept;
    logic          consume;
    logic          issue;

    // read setup
    logic [MW-1:0] cnt_ext, maxp_ext, take, skip;
    logic [AW-1:0] first_base;
    logic [AW:0]   start_sum;
    logic [AW-1:0] start_addr;
    logic [31:0]   cutoff;

    // record setup
    logic          back_in_time;
    logic          too_soon;
    logic [AW-1:0] rec_ptr;
    logic [CW-1:0] rec_fill;
    logic [6:0]    pct_sat;

    assign out_free = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == S_IDLE) && out_free;
    assign accept = cmd_valid && cmd_ready;

    assign cnt_ext    = MW'(fill_reg);
    assign maxp_ext   = MW'(point_limit);
    assign take       = (cnt_ext > maxp_ext) ? maxp_ext : cnt_ext;
    assign skip       = cnt_ext - take;
    assign first_base = (fill_reg == CW'(DEPTH)) ? wptr_reg : '0;
    assign start_sum  = (AW+1)'(first_base) + (AW+1)'(skip);
    assign start_addr = (start_sum >= (AW+1)'(DEPTH)) ?
                        AW'(start_sum - (AW+1)'(DEPTH)) : AW'(start_sum);
    assign cutoff     = (now_s > window_reg) ? (now_s - window_reg) : 32'd0;

    assign back_in_time = has_last_reg && (now_s < last_time_reg);
    assign too_soon     = has_last_reg && !back_in_time &&
                          ((now_s - last_time_reg) < {16'd0, min_interval_reg});
    assign rec_ptr      = back_in_time ? '0 : wptr_reg;
    assign rec_fill     = back_in_time ? '0 : fill_reg;
    assign pct_sat      = (sample_pct_in > {1'b0, PCT_MAX}) ? PCT_MAX : sample_pct_in[6:0];

    assign consume = (state_reg == S_READ) && pend_reg && out_free;
    assign issue   = (state_reg == S_READ) && (remain_reg != '0) && (!pend_reg || consume);

    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        last_time_next = last_time_reg;
        has_last_next  = has_last_reg;
        addr_next      = addr_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        cutoff_next    = cutoff_reg;
        wr_en          = 1'b0;
        wr_addr        = rec_ptr;
        wr_data.t      = now_s;
        wr_data.mv     = sample_mv_in;
        wr_data.pct    = pct_sat;
        rd_en          = 1'b0;
        res_load       = 1'b0;
        status_next    = ST_NONE;
        time_next      = 32'd0;
        mv_next        = 16'd0;
        pct_next       = 7'd0;
        last_next      = 1'b1;

        if (accept)
        begin
            case (op)
                OP_RECORD:
                begin
                    res_load = 1'b1;
                    if (too_soon)
                    begin
                        status_next = ST_SOON;
                    end
                    else
                    begin
                        status_next    = back_in_time ? ST_REC_CLR : ST_REC;
                        wr_en          = 1'b1;
                        wptr_next      = (rec_ptr == AW'(DEPTH - 1)) ? '0 : rec_ptr + 1'b1;
                        fill_next      = (rec_fill == CW'(DEPTH)) ? rec_fill : rec_fill + 1'b1;
                        last_time_next = now_s;
                        has_last_next  = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (take == '0)
                    begin
                        res_load    = 1'b1;
                        status_next = ST_NONE;
                    end
                    else
                    begin
                        state_next  = S_READ;
                        addr_next   = start_addr;
                        remain_next = take;
                        pend_next   = 1'b0;
                        cutoff_next = cutoff;
                    end
                end
                OP_CLEAR:
                begin
                    res_load       = 1'b1;
                    status_next    = ST_CLR;
                    wptr_next      = '0;
                    fill_next      = '0;
                    last_time_next = 32'd0;
                    has_last_next  = 1'b0;
                end
                default:
                begin
                    res_load = 1'b0;
                end
            endcase
        end

        if (consume)
        begin
            pend_next = 1'b0;
            if (rd_data.t >= cutoff_reg)
            begin
                res_load    = 1'b1;
                status_next = ST_POINT;
                time_next   = rd_data.t;
                mv_next     = rd_data.mv;
                pct_next    = rd_data.pct;
                last_next   = pend_last_reg;
            end
            else if (pend_last_reg)
            begin
                // newest entry outside the window, so nothing was emitted
                res_load    = 1'b1;
                status_next = ST_NONE;
            end
            if (pend_last_reg)
            begin
                state_next = S_IDLE;
            end
        end

        if (issue)
        begin
            rd_en          = 1'b1;
            addr_next      = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
            remain_next    = remain_reg - 1'b1;
            pend_next      = 1'b1;
            pend_last_next = (remain_reg == MW'(1));
        end

        res_valid_next = res_load ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wptr_reg         <= '0;
            fill_reg         <= '0;
            last_time_reg    <= 32'd0;
            has_last_reg     <= 1'b0;
            min_interval_reg <= MIN_INTERVAL_RST;
            window_reg       <= WINDOW_RST;
            addr_reg         <= '0;
            remain_reg       <= '0;
            pend_reg         <= 1'b0;
            pend_last_reg    <= 1'b0;
            cutoff_reg       <= 32'd0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            last_time_reg <= last_time_next;
            has_last_reg  <= has_last_next;
            addr_reg      <= addr_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            cutoff_reg    <= cutoff_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_INTERVAL: min_interval_reg <= cfg_data[15:0];
                    REG_WINDOW:       window_reg       <= cfg_data;
                    default:          window_reg       <= window_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg <= status_next;
            time_reg   <= time_next;
            mv_reg     <= mv_next;
            pct_reg    <= pct_next;
            last_reg   <= last_next;
        end
    end

    rlsh_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign point_time_s = time_reg;
    assign point_mv     = mv_reg;
    assign point_pct    = pct_reg;
    assign last         = last_reg;

    `RLSH_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH))
    `RLSH_ASSERT_IMP(a_write_not_in_scan, wr_en, state_reg == S_IDLE && !pend_reg)
    `RLSH_ASSERT_IMP(a_pending_in_scan, pend_reg, state_reg == S_READ)
    `RLSH_ASSERT_NXT(a_read_starts_scan, accept && op == OP_READ && take != '0, state_reg == S_READ)

endmodule
